[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL. Both sample on clk and are disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// When pre holds, post must hold in the next cycle.
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[hw/rtl/brb_pkg.sv]
package brb_pkg;

  localparam int DEPTH     = 256;
  localparam int PTR_W     = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = PTR_W + 1;
  localparam int CAP_W     = 9;
  localparam int MODE_W    = 3;
  localparam int DATA_W    = 8;
  localparam int ARG_W     = 8;
  localparam int LEVEL_W   = 8;
  localparam int SUM_W     = ((CNT_W > ARG_W) ? CNT_W : ARG_W) + 1;
  localparam int CMP_W     = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int LEVEL_MAX = (1 << LEVEL_W) - 1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 3'd0,
    MODE_READ  = 3'd1,
    MODE_PEEK  = 3'd2,
    MODE_SKIP  = 3'd3,
    MODE_CLEAR = 3'd4
  } brb_mode_t;

  typedef struct packed {
    logic accept;
    logic load;
  } brb_cmd_t;

endpackage

[hw/rtl/brb_if.sv]
interface brb_req_if import brb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [DATA_W-1:0]   data_in;
  logic [ARG_W-1:0]    offset_or_count;

  modport source (output valid, mode, data_in, offset_or_count, input ready);
  modport sink   (input valid, mode, data_in, offset_or_count, output ready);
endinterface

interface brb_rsp_if import brb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   data_out;
  logic                ok;
  logic [LEVEL_W-1:0]  level;

  modport source (output valid, data_out, ok, level, input ready);
  modport sink   (input valid, data_out, ok, level, output ready);
endinterface

[hw/rtl/brb_ctrl.sv]
module brb_ctrl import brb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output brb_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_LOAD
  } state_t;

  state_t state;

  assign in_ready   = (state == S_IDLE);
  assign cmd.accept = in_valid && in_ready;
  // load the result register once it is empty or being drained
  assign cmd.load   = (state == S_LOAD) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.accept) state <= S_LOAD;
          if (out_ready) out_valid <= 1'b0;
        end
        S_LOAD: begin
          if (cmd.load) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/brb_datapath.sv]
`include "assert_macros.svh"

module brb_datapath import brb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_data,
  input  brb_cmd_t           cmd,
  input  logic [MODE_W-1:0]  mode,
  input  logic [DATA_W-1:0]  data_in,
  input  logic [ARG_W-1:0]   offset_or_count,
  output logic [DATA_W-1:0]  data_out,
  output logic               ok,
  output logic [LEVEL_W-1:0] level
);

  logic [CAP_W-1:0]   capacity;
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [PTR_W-1:0]   head_next;
  logic [PTR_W-1:0]   tail_next;

  logic [CNT_W-1:0]   cap;
  logic [SUM_W-1:0]   diff;
  logic [PTR_W-1:0]   avail;
  logic [CNT_W-1:0]   tail_inc_raw;
  logic [PTR_W-1:0]   tail_inc;
  logic [ARG_W-1:0]   op_arg;
  logic [SUM_W-1:0]   hsum;
  logic [SUM_W-1:0]   hwrap;
  logic [PTR_W-1:0]   head_step;
  logic [SUM_W-1:0]   lvl_calc;
  logic [LEVEL_W-1:0] lvl_sat;
  logic [PTR_W-1:0]   rd_addr;
  logic               rd_en;
  logic               wr_en;
  logic               op_ok;

  logic [DATA_W-1:0]  mem [DEPTH];
  logic [DATA_W-1:0]  mem_q;
  logic               p_ok;
  logic               p_rd;
  logic [LEVEL_W-1:0] p_level;

  always_comb begin
    if (CMP_W'(capacity) > CMP_W'(DEPTH)) cap = CNT_W'(DEPTH);
    else cap = CNT_W'(capacity);

    diff = SUM_W'(tail) + SUM_W'(cap) - SUM_W'(head);
    if (cap == '0) avail = '0;
    else if (diff >= SUM_W'(cap)) avail = PTR_W'(diff - SUM_W'(cap));
    else avail = PTR_W'(diff);

    tail_inc_raw = CNT_W'(tail) + CNT_W'(1);
    tail_inc     = (tail_inc_raw == cap) ? '0 : PTR_W'(tail_inc_raw);

    op_arg    = (mode == MODE_READ) ? ARG_W'(1) : offset_or_count;
    hsum      = SUM_W'(head) + SUM_W'(op_arg);
    hwrap     = (hsum >= SUM_W'(cap)) ? hsum - SUM_W'(cap) : hsum;
    head_step = PTR_W'(hwrap);

    head_next = head;
    tail_next = tail;
    op_ok     = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = head;
    lvl_calc  = SUM_W'(avail);

    unique case (brb_mode_t'(mode))
      MODE_CLEAR: begin
        head_next = '0;
        tail_next = '0;
        op_ok     = 1'b1;
        lvl_calc  = '0;
      end
      MODE_WRITE: begin
        if (cap != '0 && tail_inc != head) begin
          wr_en     = 1'b1;
          tail_next = tail_inc;
          op_ok     = 1'b1;
          lvl_calc  = SUM_W'(avail) + SUM_W'(1);
        end
      end
      MODE_READ: begin
        if (cap != '0 && avail != '0) begin
          rd_en = 1'b1;
          op_ok = 1'b1;
          if (avail == PTR_W'(1)) begin
            head_next = '0;
            tail_next = '0;
            lvl_calc  = '0;
          end else begin
            head_next = head_step;
            lvl_calc  = SUM_W'(avail) - SUM_W'(1);
          end
        end
      end
      MODE_PEEK: begin
        if (cap != '0 && SUM_W'(offset_or_count) < SUM_W'(avail)) begin
          rd_en   = 1'b1;
          rd_addr = head_step;
          op_ok   = 1'b1;
        end
      end
      MODE_SKIP: begin
        if (cap != '0 && SUM_W'(offset_or_count) <= SUM_W'(avail)) begin
          op_ok = 1'b1;
          if (SUM_W'(offset_or_count) == SUM_W'(avail)) begin
            head_next = '0;
            tail_next = '0;
            lvl_calc  = '0;
          end else begin
            head_next = head_step;
            lvl_calc  = SUM_W'(avail) - SUM_W'(offset_or_count);
          end
        end
      end
      default: ;
    endcase

    lvl_sat = (lvl_calc > SUM_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(lvl_calc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      head     <= '0;
      tail     <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_data;
      head     <= '0;
      tail     <= '0;
    end else if (cmd.accept) begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) mem[tail] <= data_in;
    if (cmd.accept && rd_en) mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_ok    <= op_ok;
      p_rd    <= rd_en;
      p_level <= lvl_sat;
    end
    if (cmd.load) begin
      data_out <= p_rd ? mem_q : '0;
      ok       <= p_ok;
      level    <= p_level;
    end
  end

  `ASSERT_ALWAYS(a_ptr_range, cap == '0 || (CNT_W'(head) < cap && CNT_W'(tail) < cap))
  `ASSERT_NEXT(a_clear_ptrs, cmd.accept && mode == MODE_CLEAR, head == '0 && tail == '0)
  `ASSERT_NEXT(a_fail_zero, cmd.load && !p_ok, data_out == '0)

endmodule

[hw/rtl/byte_ring_buffer.sv]
// Byte ring buffer. Each request item carries a mode (write, read, peek at an
// offset from the head, skip a count of bytes, clear) and yields exactly one
// response item with data_out, ok and the fill level after the operation. The
// ring uses `capacity` slots (config register, reset 256, saturating at DEPTH)
// and keeps one slot free, so it holds at most capacity-1 bytes; a capacity
// of 0 disables every mode except clear. Writing capacity clears both
// pointers, and so does any read or skip that empties the ring. A refused or
// unavailable operation returns ok low and data_out 0. The accept step
// updates the pointers and starts the single store access (write or
// registered read); the load step that follows fills the response
// register. req.ready is high whenever the controller is idle, so the next
// item is accepted while the previous response still waits in its register;
// a stalled response holds the controller in its load step. The byte store
// is not cleared after reset: only entries between head and tail are ever
// read, and those have been written. Write capacity only while no item is
// in flight.
module byte_ring_buffer import brb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  brb_req_if.sink          req,
  brb_rsp_if.source        rsp
);

  brb_cmd_t cmd;

  // sequencing: accept, then load the response register
  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // pointers, capacity, byte store and response register
  brb_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .mode            (req.mode),
    .data_in         (req.data_in),
    .offset_or_count (req.offset_or_count),
    .data_out        (rsp.data_out),
    .ok              (rsp.ok),
    .level           (rsp.level)
  );

endmodule

[test/tb_byte_ring_buffer.sv]
module tb_byte_ring_buffer;
  import brb_pkg::*;

  // Unused mode codes sit above clear; the block must answer them with ok low.
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = MODE_W'(MODE_CLEAR) + 1'b1;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = '1;

  // Receiver hold-off long enough to back the block up into its request side.
  localparam int LONG_HOLD  = 150;
  // Far above the slowest legal run: every item paying the longest gap and
  // the longest response stall, plus the hold-off and the phase drains.
  localparam int MAX_CYCLES = 400000;

  typedef struct packed {
    logic [DATA_W-1:0]  data_out;
    logic               ok;
    logic [LEVEL_W-1:0] level;
  } ring_result_t;

  // Ring predictor plus the queue of responses it expects, oldest first.
  class ring_scoreboard;
    logic [DATA_W-1:0] ring_mem [DEPTH];
    int unsigned       head;
    int unsigned       tail;
    logic [CAP_W-1:0]  capacity;
    ring_result_t      expected_q[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       full_refusals;
    int unsigned       range_refusals;

    function new();
      head           = 0;
      tail           = 0;
      capacity       = CAP_RESET;
      errors         = 0;
      checked        = 0;
      full_refusals  = 0;
      range_refusals = 0;
    endfunction

    function int unsigned slots();
      return (capacity > DEPTH) ? DEPTH : capacity;
    endfunction

    function int unsigned fill();
      int unsigned c;
      c = slots();
      if (c == 0) return 0;
      return (tail + c - head) % c;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
      head     = 0;
      tail     = 0;
    endfunction

    // Apply one accepted request item to the ring and queue its response.
    function void note_item(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] din,
                            logic [ARG_W-1:0] arg);
      int unsigned  c;
      int unsigned  avail;
      int unsigned  nt;
      int unsigned  lvl;
      ring_result_t r;
      c = slots();
      r = '0;
      if (mode == MODE_CLEAR) begin
        head = 0;
        tail = 0;
        r.ok = 1'b1;
      end else if (c != 0) begin
        avail = fill();
        case (mode)
          MODE_WRITE: begin
            nt = (tail + 1) % c;
            if (nt != head) begin
              ring_mem[tail] = din;
              tail = nt;
              r.ok = 1'b1;
            end else if (c > 1) begin
              full_refusals++;
            end
          end
          MODE_READ: begin
            if (avail != 0) begin
              r.data_out = ring_mem[head];
              head = (head + 1) % c;
              if (head == tail) begin
                head = 0;
                tail = 0;
              end
              r.ok = 1'b1;
            end
          end
          MODE_PEEK: begin
            if (arg < avail) begin
              r.data_out = ring_mem[(head + arg) % c];
              r.ok = 1'b1;
            end else begin
              range_refusals++;
            end
          end
          MODE_SKIP: begin
            if (arg <= avail) begin
              head = (head + arg) % c;
              if (head == tail) begin
                head = 0;
                tail = 0;
              end
              r.ok = 1'b1;
            end else begin
              range_refusals++;
            end
          end
          default: ;
        endcase
      end
      lvl = fill();
      r.level = (lvl > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(lvl);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [DATA_W-1:0] data_out, logic ok,
                               logic [LEVEL_W-1:0] level);
      ring_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected response data_out=%0d ok=%0d level=%0d",
                 $time, data_out, ok, level);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (data_out !== e.data_out) begin
        errors++;
        $display("%0t: data_out mismatch: expected %0d, actual %0d",
                 $time, e.data_out, data_out);
      end
      if (ok !== e.ok) begin
        errors++;
        $display("%0t: ok mismatch: expected %0d, actual %0d", $time, e.ok, ok);
      end
      if (level !== e.level) begin
        errors++;
        $display("%0t: level mismatch: expected %0d, actual %0d",
                 $time, e.level, level);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;

  brb_req_if req_ch ();
  brb_rsp_if rsp_ch ();

  byte_ring_buffer dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  ring_scoreboard sb = new();

  // steady: no gaps on either side for the current phase.
  // hold_rsp_long: raised by the stimulus, cleared by the receiver once it
  // has started counting its hold-off.
  bit          steady;
  bit          hold_rsp_long;
  int unsigned cycle_count;

  // Capacity settings walked by the random part: reset value, tiny rings,
  // mid sizes, values above DEPTH (saturate), all ones, one, and zero.
  int phase_cap    [10] = '{256, 2, 3, 17, 300, 511, 1, 0, 64, 256};
  int phase_len    [10] = '{500, 100, 100, 200, 250, 100, 30, 30, 160, 80};
  bit phase_steady [10] = '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: end the run if the handshakes ever stop moving.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
        $display("%0t: timeout with %0d responses outstanding",
                 $time, sb.expected_q.size());
        $display("tb_byte_ring_buffer: errors");
        $finish;
      end
    end
  end

  // Response side: mostly ready, short stalls, a few long ones, and the
  // requested long hold-off counted here so the sender keeps pushing.
  initial begin : rsp_side
    int stall_left;
    int r;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp_long) begin
        stall_left    = LONG_HOLD;
        hold_rsp_long = 1'b0;
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (steady) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          rsp_ch.ready <= 1'b1;
        end else begin
          stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(9, 39);
          rsp_ch.ready <= 1'b0;
        end
      end
    end
  end

  // Check every response accepted at this edge against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_result(rsp_ch.data_out, rsp_ch.ok, rsp_ch.level);
  end

  // Pick the idle cycles after a request item: mostly none, sometimes a few,
  // now and then a long pause.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one request item and hold it until accepted; predict at acceptance.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] din,
                           input logic [ARG_W-1:0] arg);
    int gap;
    req_ch.mode            <= mode;
    req_ch.data_in         <= din;
    req_ch.offset_or_count <= arg;
    req_ch.valid           <= 1'b1;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_item(mode, din, arg);
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted response has come back, then
  // let the pipeline settle.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input int value);
    cfg_data <= CAP_W'(value);
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(CAP_W'(value));
  endtask

  // Random item shaped by the phase: filling leans on writes to reach a full
  // ring, draining mixes writes, reads, peeks, skips and the odd clear. Peek
  // offsets and skip counts cluster around the current fill level and its edge.
  task automatic random_item(input bit filling);
    int                r;
    int                lvl;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] din;
    logic [ARG_W-1:0]  arg;
    lvl  = sb.fill();
    r    = $urandom_range(0, 99);
    din  = DATA_W'($urandom_range(0, 255));
    arg  = ARG_W'($urandom_range(0, 255));
    mode = MODE_UNUSED_LO + MODE_W'($urandom_range(0, 2));
    if (filling) begin
      if (r < 82)      mode = MODE_WRITE;
      else if (r < 87) mode = MODE_READ;
      else if (r < 95) mode = MODE_PEEK;
      else if (r < 97) mode = MODE_SKIP;
    end else begin
      if (r < 33)      mode = MODE_WRITE;
      else if (r < 68) mode = MODE_READ;
      else if (r < 83) mode = MODE_PEEK;
      else if (r < 95) mode = MODE_SKIP;
      else if (r < 97) mode = MODE_CLEAR;
    end
    if (mode == MODE_PEEK && $urandom_range(0, 99) < 70)
      arg = ARG_W'($urandom_range(0, lvl));
    if (mode == MODE_SKIP) begin
      r = $urandom_range(0, 99);
      if (r < 55)      arg = ARG_W'($urandom_range(0, (lvl < 4) ? lvl : 4));
      else if (r < 80) arg = ARG_W'(lvl);
      else if (r < 90 && lvl < 255) arg = ARG_W'(lvl + 1);
    end
    send_item(mode, din, arg);
  endtask

  initial begin : stimulus
    bit filling;
    int lvl;
    steady        = 1'b0;
    hold_rsp_long = 1'b0;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_data      <= '0;
    req_ch.valid           <= 1'b0;
    req_ch.mode            <= MODE_CLEAR;
    req_ch.data_in         <= '0;
    req_ch.offset_or_count <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty ring at reset capacity, byte extremes, peek inside and
    // past the level, skips past and at the level, unused modes, clear.
    send_item(MODE_READ,  8'h00, 8'd0);
    send_item(MODE_PEEK,  8'h00, 8'd0);
    send_item(MODE_SKIP,  8'h00, 8'd0);
    send_item(MODE_SKIP,  8'h00, 8'd1);
    send_item(MODE_WRITE, 8'h00, 8'd0);
    send_item(MODE_WRITE, 8'hFF, 8'd0);
    send_item(MODE_WRITE, 8'hA5, 8'hFF);
    send_item(MODE_PEEK,  8'h00, 8'd0);
    send_item(MODE_PEEK,  8'h00, 8'd2);
    send_item(MODE_PEEK,  8'h00, 8'd3);
    send_item(MODE_PEEK,  8'h00, 8'd255);
    send_item(MODE_READ,  8'h00, 8'd0);
    send_item(MODE_SKIP,  8'h00, 8'd3);
    send_item(MODE_SKIP,  8'h00, 8'd2);
    send_item(MODE_UNUSED_LO, 8'h5A, 8'd0);
    send_item(MODE_UNUSED_HI, 8'h5A, 8'd0);
    send_item(MODE_WRITE, 8'h5A, 8'd0);
    send_item(MODE_CLEAR, 8'h00, 8'd0);

    // Disabled ring: everything refused except clear.
    drain();
    write_capacity(0);
    send_item(MODE_WRITE, 8'h33, 8'd0);
    send_item(MODE_READ,  8'h00, 8'd0);
    send_item(MODE_CLEAR, 8'h00, 8'd0);

    // One-slot ring: no byte ever fits.
    drain();
    write_capacity(1);
    send_item(MODE_WRITE, 8'h77, 8'd0);
    send_item(MODE_PEEK,  8'h00, 8'd0);

    // Random phases, one per capacity setting, each entered from idle.
    foreach (phase_cap[p]) begin
      drain();
      write_capacity(phase_cap[p]);
      steady  = phase_steady[p];
      filling = 1'b1;
      for (int i = 0; i < phase_len[p]; i++) begin
        // Pause the sender until every response is back, once.
        if (p == 0 && i == 120) drain();
        // Hold the receiver off while writes keep coming, once.
        if (p == 0 && i == 220) hold_rsp_long = 1'b1;
        lvl = sb.fill();
        if (filling && lvl + 1 >= sb.slots()) filling = 1'b0;
        else if (!filling && lvl == 0) filling = 1'b1;
        else if (!filling && $urandom_range(0, 99) < 1) filling = 1'b1;
        random_item(filling);
      end
    end
    steady = 1'b0;

    req_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d responses across %0d capacity settings (0 through 511).",
             sb.checked, $size(phase_cap) + 3);
    $display("Writes refused on a full ring: %0d; peeks/skips past the level: %0d.",
             sb.full_refusals, sb.range_refusals);
    if (sb.errors == 0) begin
      $display("tb_byte_ring_buffer: clean");
    end else begin
      $display("tb_byte_ring_buffer: errors");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/brb_pkg.sv
hw/rtl/brb_if.sv
hw/rtl/brb_ctrl.sv
hw/rtl/brb_datapath.sv
hw/rtl/byte_ring_buffer.sv
test/tb_byte_ring_buffer.sv
